@@ design/twc_pkg.sv @@
// Package for the time-over-threshold walk corrector.
// Holds the default field widths and the register index codes; depends on nothing.
package twc_pkg;

  localparam int TIME_WIDTH   = 16;
  localparam int CHARGE_WIDTH = 24;

  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RISE_TIME        = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRAIN_CURRENT    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD_CHARGE = 2'd2;

endpackage

@@ design/tot_time_walk_correction_top.sv @@
// Top level of the time-over-threshold walk corrector.
// Depends on twc_pkg, twc_sqrt_step and twc_div_step.

// This block turns one pixel hit's time over threshold into the deposited
// charge and the time walk that this charge causes. A hit is taken at every
// clock edge where start is high; busy is always low, so one hit may follow
// another in every cycle. Each result beat stays on the result ports for
// one cycle, marked by done. The receiver cannot stall the block, so results
// must be taken as they come. The pipeline holds three stages of products,
// one stage per charge bit in the root search, one stage for the range check
// of the walk, one stage per walk bit in the division, and the output
// register. Configuration registers (rise time, drain current, threshold)
// are written through cfg_write, cfg_index and cfg_data and should only be
// changed while no hit is in flight. Writes to an unknown index are ignored.
module tot_time_walk_correction_top #(
  parameter int TIME_WIDTH   = twc_pkg::TIME_WIDTH,
  parameter int CHARGE_WIDTH = twc_pkg::CHARGE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [TIME_WIDTH-1:0]                over_threshold_time,
  output logic                                 done,
  output logic [CHARGE_WIDTH-1:0]              deposited_charge,
  output logic [TIME_WIDTH-1:0]                walk_delay,
  output logic                                 walk_saturated,
  input  logic                                 cfg_write,
  input  logic [twc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [((TIME_WIDTH > CHARGE_WIDTH) ? TIME_WIDTH : CHARGE_WIDTH)-1:0] cfg_data
);

  localparam int TW   = TIME_WIDTH;
  localparam int CW   = CHARGE_WIDTH;
  localparam int RTW  = TW + CW;          // width of R*T, R*I and tot*I
  localparam int RTIW = TW + 2 * CW;      // width of R*T*I
  localparam int FW   = TW + 2 * CW + 4;  // signed width of the root search terms
  localparam int HALF = (RTW + 1) / 2;    // split of R*T for the R*T*I product
  localparam int LAT  = 5 + CW + TW;

  // The block never refuses a hit.
  assign busy = 1'b0;

  // Configuration registers.
  logic [TW-1:0] rise_time;
  logic [CW-1:0] drain_current;
  logic [CW-1:0] threshold_charge;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_time        <= '0;
      drain_current    <= '0;
      threshold_charge <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        twc_pkg::REG_RISE_TIME:        rise_time        <= cfg_data[TW-1:0];
        twc_pkg::REG_DRAIN_CURRENT:    drain_current    <= cfg_data[CW-1:0];
        twc_pkg::REG_THRESHOLD_CHARGE: threshold_charge <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Stage A: the three first-level products.
  logic           a_valid;
  logic [RTW-1:0] a_rt;
  logic [RTW-1:0] a_ri;
  logic [RTW-1:0] a_ti;
  logic [CW-1:0]  a_thr;
  logic [CW-1:0]  a_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start;
    end
    a_rt  <= RTW'(rise_time) * RTW'(threshold_charge);
    a_ri  <= RTW'(rise_time) * RTW'(drain_current);
    a_ti  <= RTW'(over_threshold_time) * RTW'(drain_current);
    a_thr <= threshold_charge;
    a_cur <= drain_current;
  end

  // Stage B: the linear coefficient c = 256*T + tot*I - R*I, and the two
  // partial products of R*T*I.
  logic                 b_valid;
  logic [RTW-1:0]       b_rt;
  logic signed [FW-1:0] b_c;
  logic [RTIW-1:0]      b_plo;
  logic [RTIW-1:0]      b_phi;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_rt  <= a_rt;
    b_c   <= $signed({{(FW-CW-8){1'b0}}, a_thr, 8'b0})
           + $signed({{(FW-RTW){1'b0}}, a_ti})
           - $signed({{(FW-RTW){1'b0}}, a_ri});
    b_plo <= RTIW'(a_rt[HALF-1:0]) * RTIW'(a_cur);
    b_phi <= RTIW'(a_rt[RTW-1:HALF]) * RTIW'(a_cur);
  end

  // Stage C: full R*T*I; the search starts from q = 0 with f = -R*T*I.
  logic                 c_valid;
  logic [RTW-1:0]       c_rt;
  logic signed [FW-1:0] c_c;
  logic signed [FW-1:0] c_f;
  logic [RTIW-1:0]      c_rti;

  assign c_rti = b_plo + (b_phi << HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_rt <= b_rt;
    c_c  <= b_c;
    c_f  <= -$signed({{(FW-RTIW){1'b0}}, c_rti});
  end

  // Root search, most significant charge bit first, one bit per stage.
  logic                 sq_valid [0:CW];
  logic [CW-1:0]        sq_q     [0:CW];
  logic signed [FW-1:0] sq_f     [0:CW];
  logic signed [FW-1:0] sq_c     [0:CW];
  logic [RTW-1:0]       sq_rt    [0:CW];

  assign sq_valid[0] = c_valid;
  assign sq_q[0]     = '0;
  assign sq_f[0]     = c_f;
  assign sq_c[0]     = c_c;
  assign sq_rt[0]    = c_rt;

  for (genvar s = 0; s < CW; s++) begin : g_sqrt
    twc_sqrt_step #(.TW(TW), .CW(CW), .FW(FW), .BIT(CW - 1 - s)) u_step (
      .clk      (clk),
      .rst      (rst),
      .valid_in (sq_valid[s]),
      .q_in     (sq_q[s]),
      .f_in     (sq_f[s]),
      .c_in     (sq_c[s]),
      .rt_in    (sq_rt[s]),
      .valid_out(sq_valid[s+1]),
      .q_out    (sq_q[s+1]),
      .f_out    (sq_f[s+1]),
      .c_out    (sq_c[s+1]),
      .rt_out   (sq_rt[s+1])
    );
  end

  // Range check: the walk saturates when the charge is zero or when
  // R*T reaches charge * 2^TIME_WIDTH.
  logic             dv_valid [0:TW];
  logic [CW-1:0]    dv_q     [0:TW];
  logic [RTW-1:0]   dv_rem   [0:TW];
  logic [TW-1:0]    dv_quo   [0:TW];
  logic             dv_sat   [0:TW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= sq_valid[CW];
    end
    dv_q[0]   <= sq_q[CW];
    dv_rem[0] <= sq_rt[CW];
    dv_quo[0] <= '0;
    dv_sat[0] <= (sq_q[CW] == '0)
              || ({1'b0, sq_rt[CW]} >= ({{(TW+1){1'b0}}, sq_q[CW]} << TW));
  end

  for (genvar s = 0; s < TW; s++) begin : g_div
    twc_div_step #(.TW(TW), .CW(CW), .BIT(TW - 1 - s)) u_step (
      .clk      (clk),
      .rst      (rst),
      .valid_in (dv_valid[s]),
      .q_in     (dv_q[s]),
      .rem_in   (dv_rem[s]),
      .quo_in   (dv_quo[s]),
      .sat_in   (dv_sat[s]),
      .valid_out(dv_valid[s+1]),
      .q_out    (dv_q[s+1]),
      .rem_out  (dv_rem[s+1]),
      .quo_out  (dv_quo[s+1]),
      .sat_out  (dv_sat[s+1])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[TW];
    end
    deposited_charge <= dv_q[TW];
    walk_delay       <= dv_sat[TW] ? {TW{1'b1}} : dv_quo[TW];
    walk_saturated   <= dv_sat[TW];
  end

`ifndef SYNTHESIS
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("result beat did not appear at the fixed latency");

  a_no_ghost_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result beat without a matching hit");

  a_zero_charge_flag: assert property (@(posedge clk) disable iff (rst)
    (done && deposited_charge == '0) |-> walk_saturated)
    else $error("zero charge without saturation flag");

  a_flag_max_walk: assert property (@(posedge clk) disable iff (rst)
    (done && walk_saturated) |-> (walk_delay == {TW{1'b1}}))
    else $error("saturated walk is not the largest value");
`endif

endmodule

@@ design/twc_sqrt_step.sv @@
// One pipeline stage of the bit-by-bit charge root search.
// Depends on nothing; instantiated by tot_time_walk_correction_top.
module twc_sqrt_step #(
  parameter int TW  = 16,
  parameter int CW  = 24,
  parameter int FW  = 68,
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  logic [CW-1:0]        q_in,
  input  logic signed [FW-1:0] f_in,
  input  logic signed [FW-1:0] c_in,
  input  logic [TW+CW-1:0]     rt_in,
  output logic                 valid_out,
  output logic [CW-1:0]        q_out,
  output logic signed [FW-1:0] f_out,
  output logic signed [FW-1:0] c_out,
  output logic [TW+CW-1:0]     rt_out
);

  // f holds 256*q*q - c*q - rti; setting bit BIT adds (512q + 256*2^BIT - c) * 2^BIT.
  logic signed [FW-1:0] term;
  logic signed [FW-1:0] f_try;

  always_comb begin
    term  = $signed({{(FW-CW-9){1'b0}}, q_in, 9'b0})
          + ($signed(FW'(256)) <<< BIT) - c_in;
    f_try = f_in + (term <<< BIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    c_out  <= c_in;
    rt_out <= rt_in;
    if (f_try <= $signed(FW'(0))) begin
      q_out <= q_in | (CW'(1) << BIT);
      f_out <= f_try;
    end else begin
      q_out <= q_in;
      f_out <= f_in;
    end
  end

endmodule

@@ design/twc_div_step.sv @@
// One pipeline stage of the restoring division of R*T by the charge.
// Depends on nothing; instantiated by tot_time_walk_correction_top.
module twc_div_step #(
  parameter int TW  = 16,
  parameter int CW  = 24,
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid_in,
  input  logic [CW-1:0]    q_in,
  input  logic [TW+CW-1:0] rem_in,
  input  logic [TW-1:0]    quo_in,
  input  logic             sat_in,
  output logic             valid_out,
  output logic [CW-1:0]    q_out,
  output logic [TW+CW-1:0] rem_out,
  output logic [TW-1:0]    quo_out,
  output logic             sat_out
);

  logic [TW+CW-1:0] sub;

  assign sub = {{TW{1'b0}}, q_in} << BIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    q_out   <= q_in;
    sat_out <= sat_in;
    if (rem_in >= sub) begin
      rem_out <= rem_in - sub;
      quo_out <= quo_in | (TW'(1) << BIT);
    end else begin
      rem_out <= rem_in;
      quo_out <= quo_in;
    end
  end

endmodule

@@ bench/tb.sv @@
// Testbench for the time-over-threshold walk corrector.
// Depends on twc_pkg and tot_time_walk_correction_top; stands alone otherwise.
`timescale 1ns / 100ps

module tb;

  localparam int TW = twc_pkg::TIME_WIDTH;
  localparam int CW = twc_pkg::CHARGE_WIDTH;
  localparam int DW = (TW > CW) ? TW : CW;
  // Pipeline depth of the top level.
  localparam int LATENCY = 5 + CW + TW;
  localparam int CYCLE_LIMIT = 300000;
  // An index that decodes to no register.
  localparam logic [twc_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CW-1:0] charge;
    logic [TW-1:0] walk;
    logic          sat;
  } hit_result_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  logic [TW-1:0] over_threshold_time;
  logic          done;
  logic [CW-1:0] deposited_charge;
  logic [TW-1:0] walk_delay;
  logic          walk_saturated;
  logic          cfg_write;
  logic [twc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  tot_time_walk_correction_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .over_threshold_time(over_threshold_time),
    .done(done), .deposited_charge(deposited_charge),
    .walk_delay(walk_delay), .walk_saturated(walk_saturated),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Our own copy of the configuration, updated at the edge that writes it.
  logic [TW-1:0] rise_q;
  logic [CW-1:0] drain_q;
  logic [CW-1:0] thresh_q;

  hit_result_t pending_hits[$];
  int errors;
  int hits_sent;
  int beats_checked;
  int cycles;
  int idle_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The charge is the largest q whose quadratic stays at or below the
  // constant term. The search walks the charge bits from the top, so a root
  // beyond the field range comes out as all ones, which is the saturation.
  function automatic hit_result_t predict_hit(logic [TW-1:0] tot);
    logic [127:0] rt, ri, rti, lhs, rhs, trial, q, walk;
    hit_result_t r;
    rt  = 128'(rise_q) * 128'(thresh_q);
    ri  = 128'(rise_q) * 128'(drain_q);
    rti = rt * 128'(drain_q);
    q = '0;
    for (int b = CW - 1; b >= 0; b--) begin
      trial = q | (128'd1 << b);
      lhs = ((trial * trial) << 8) + ri * trial;
      rhs = rti + (128'(thresh_q) << 8) * trial + 128'(tot) * 128'(drain_q) * trial;
      if (lhs <= rhs) q = trial;
    end
    r.charge = q[CW-1:0];
    r.sat = 1'b0;
    if (q == 0) begin
      r.walk = '1;
      r.sat = 1'b1;
    end else begin
      walk = rt / q;
      if (walk > 128'({TW{1'b1}})) begin
        r.walk = '1;
        r.sat = 1'b1;
      end else begin
        r.walk = walk[TW-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (R=%0d I=%0d T=%0d)",
             what, got, want, rise_q, drain_q, thresh_q);
  endtask

  // Every done beat is matched against the oldest hit still in flight.
  always @(posedge clk) begin
    hit_result_t want;
    if (!rst && done) begin
      if (pending_hits.size() == 0) begin
        errors++;
        $display("MISMATCH: result beat with no hit in flight");
      end else begin
        want = pending_hits.pop_front();
        beats_checked++;
        if (deposited_charge !== want.charge)
          report_mismatch("deposited_charge", deposited_charge, want.charge);
        if (walk_delay !== want.walk)
          report_mismatch("walk_delay", walk_delay, want.walk);
        if (walk_saturated !== want.sat)
          report_mismatch("walk_saturated", walk_saturated, want.sat);
      end
    end
  end

  // Hard stop in case the block never answers.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Leaves cfg_write high; the caller lowers it after its last write.
  task automatic write_reg(logic [twc_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [DW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      twc_pkg::REG_RISE_TIME:        rise_q   = data[TW-1:0];
      twc_pkg::REG_DRAIN_CURRENT:    drain_q  = data[CW-1:0];
      twc_pkg::REG_THRESHOLD_CHARGE: thresh_q = data[CW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [TW-1:0] r, logic [CW-1:0] i, logic [CW-1:0] t);
    write_reg(twc_pkg::REG_RISE_TIME, DW'(r));
    write_reg(twc_pkg::REG_DRAIN_CURRENT, DW'(i));
    write_reg(twc_pkg::REG_THRESHOLD_CHARGE, DW'(t));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one hit and records its expectation at the accepting edge. start
  // stays high so back-to-back hits need no second assignment in one step;
  // with a chance of idle_pct percent the sender then lowers start and pauses.
  task automatic send_hit(logic [TW-1:0] tot);
    start <= 1'b1;
    over_threshold_time <= tot;
    do @(posedge clk); while (busy);
    pending_hits.push_back(predict_hit(tot));
    hits_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every hit in flight has come back or a guard
  // runs out, then adds a margin so the next register write lands on an idle block.
  task automatic drain;
    int guard;
    start <= 1'b0;
    guard = 0;
    while (pending_hits.size() != 0 && guard < 4 * LATENCY) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [TW-1:0] rand_tot();
    case ($urandom_range(3))
      0: return TW'($urandom);
      1: return TW'($urandom_range(0, 255));
      2: return TW'($urandom_range(0, 4095));
      default: return TW'($urandom_range(0, 1023) + 16'd1000);
    endcase
  endfunction

  // Registers are still at zero after reset: no charge, flagged walk.
  task automatic test_reset_values;
    send_hit('0);
    send_hit('1);
    drain();
  endtask

  // Field extremes under a typical and under extreme configurations.
  task automatic test_directed;
    set_config(16'd1600, 24'd25600, 24'd1000);
    send_hit('0);
    send_hit(16'd1);
    send_hit(16'd160);
    send_hit(16'h8000);
    send_hit('1);
    drain();
    set_config('1, '1, '1);
    send_hit('0);
    send_hit('1);
    drain();
    // Zero threshold: zero walk, no flag unless the charge is zero.
    set_config(16'd1600, 24'd256, '0);
    send_hit('0);
    send_hit(16'd500);
    drain();
    // Tiny current against a large threshold drives the charge to saturation.
    set_config(16'd1, 24'd1, '1);
    send_hit('1);
    send_hit('0);
    drain();
    // Large rise time times threshold over a small charge drives the walk to its largest value without saturating.
    set_config('1, '1, 24'd3000);
    send_hit('0);
    send_hit(16'd2);
    drain();
    set_config('0, '1, '1);
    send_hit(16'd77);
    drain();
  endtask

  // A write to the unused index must leave all registers alone, and the
  // rise time keeps only its low bits.
  task automatic test_register_decode;
    set_config(16'd800, 24'd12800, 24'd2000);
    write_reg(REG_UNUSED, '1);
    write_reg(twc_pkg::REG_RISE_TIME, {{(DW-TW){1'b1}}, 16'd1234});
    cfg_write <= 1'b0;
    @(posedge clk);
    send_hit(16'd300);
    send_hit(16'd4000);
    drain();
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        drain();
        case ($urandom_range(3))
          0: set_config(TW'($urandom), CW'($urandom), CW'($urandom));
          1: set_config(TW'($urandom_range(100, 4000)), CW'($urandom_range(256, 100000)),
                        CW'($urandom_range(500, 5000)));
          2: set_config(TW'($urandom_range(0, 3)), CW'($urandom_range(0, 3)),
                        CW'($urandom));
          default: set_config('1, CW'($urandom_range(1, 300)), '1);
        endcase
      end
      send_hit(rand_tot());
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    over_threshold_time = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rise_q = '0;
    drain_q = '0;
    thresh_q = '0;
    errors = 0;
    hits_sent = 0;
    beats_checked = 0;
    cycles = 0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_directed();
    test_register_decode();
    // Back to back, sender pausing after about half the hits, back to back again, then after about a quarter.
    test_random(400, 0);
    test_random(400, 51);
    test_random(400, 0);
    test_random(400, 26);

    drain();
    repeat (LATENCY + 5) @(posedge clk);
    if (pending_hits.size() != 0) begin
      errors++;
      $display("MISMATCH: %0d hits never answered", pending_hits.size());
    end
    $display("Covered %0d hits and %0d result beats over many register settings,",
             hits_sent, beats_checked);
    $display("including zero, saturated and out-of-range cases, with %0d errors.", errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
